// ----- rtl/fct_pkg.sv -----
`timescale 1ns / 1ps
package fct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CMD_BITS   = 3;
    localparam int IDX_BITS   = 3;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_LOAD      = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_BOX_ALL   = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_BOX_SKIP  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_BOX_SIDES = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_SPHERE    = 3'd4;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic [IDX_BITS-1:0] plane_index;
        t_coord              val_x;
        t_coord              val_y;
        t_coord              val_z;
        t_coord              val_w;
        t_coord              hi_x;
        t_coord              hi_y;
        t_coord              hi_z;
    } t_req;

    typedef struct packed {
        logic is_test;
        logic visible;
    } t_rsp;

    // request as it travels down the cell chain
    typedef struct packed {
        logic valid;
        t_req req;
        logic vis;
    } t_flow;

endpackage

// ----- rtl/fct_cell.sv -----
`timescale 1ns / 1ps
module fct_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fct_pkg::t_flow i_flow,
    output fct_pkg::t_flow o_flow
);
    import fct_pkg::*;

    localparam int PW = 2 * COORD_BITS;
    localparam int SW = PW + 3;
    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    // plane held by this cell
    t_coord r_a, r_b, r_c, r_d;

    // multiply stage
    t_flow                r_m_flow;
    logic signed [PW-1:0] r_px, r_py, r_pz;
    t_coord               r_md;
    logic                 r_act;
    logic                 r_sph;

    // sum stage
    t_flow                r_s_flow;

    t_coord               qx, qy, qz;
    logic                 act;
    logic                 sph;
    logic                 load_hit;
    logic signed [PW-1:0] px, py, pz;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] d_term;
    logic signed [SW-1:0] r_term;

    assign load_hit = i_flow.valid && (i_flow.req.cmd == CMD_LOAD)
                      && (i_flow.req.plane_index == MY_IDX);
    assign sph = (i_flow.req.cmd == CMD_SPHERE);

    always_comb begin
        case (i_flow.req.cmd)
            CMD_BOX_ALL:   act = 1'b1;
            CMD_BOX_SKIP:  act = (CELL_IDX >= 1);
            CMD_BOX_SIDES: act = (CELL_IDX >= 2);
            CMD_SPHERE:    act = 1'b1;
            default:       act = 1'b0;
        endcase
    end

    // pick the corner furthest along the normal; the sphere uses its center
    assign qx = (!sph && r_a[COORD_BITS-1]) ? i_flow.req.val_x
              : (sph ? i_flow.req.val_x : i_flow.req.hi_x);
    assign qy = (!sph && r_b[COORD_BITS-1]) ? i_flow.req.val_y
              : (sph ? i_flow.req.val_y : i_flow.req.hi_y);
    assign qz = (!sph && r_c[COORD_BITS-1]) ? i_flow.req.val_z
              : (sph ? i_flow.req.val_z : i_flow.req.hi_z);

    assign px = r_a * qx;
    assign py = r_b * qy;
    assign pz = r_c * qz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
        end else if (load_hit) begin
            r_a <= i_flow.req.val_x;
            r_b <= i_flow.req.val_y;
            r_c <= i_flow.req.val_z;
            r_d <= i_flow.req.val_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_flow.valid <= 1'b0;
        end else begin
            r_m_flow.valid <= i_flow.valid;
        end
        r_m_flow.req <= i_flow.req;
        r_m_flow.vis <= i_flow.vis;
        r_px         <= px;
        r_py         <= py;
        r_pz         <= pz;
        r_md         <= r_d;
        r_act        <= act;
        r_sph        <= sph;
    end

    // d and radius align with the product fraction
    assign d_term = $signed({{(SW-COORD_BITS-FRAC_BITS){r_md[COORD_BITS-1]}},
                             r_md, {FRAC_BITS{1'b0}}});
    assign r_term = r_sph
        ? $signed({{(SW-COORD_BITS-FRAC_BITS){r_m_flow.req.val_w[COORD_BITS-1]}},
                   r_m_flow.req.val_w, {FRAC_BITS{1'b0}}})
        : '0;

    assign sum = $signed({{3{r_px[PW-1]}}, r_px}) + $signed({{3{r_py[PW-1]}}, r_py})
               + $signed({{3{r_pz[PW-1]}}, r_pz}) + d_term + r_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_flow.valid <= 1'b0;
        end else begin
            r_s_flow.valid <= r_m_flow.valid;
        end
        r_s_flow.req <= r_m_flow.req;
        r_s_flow.vis <= r_m_flow.vis & ~(r_act & sum[SW-1]);
    end

    assign o_flow = r_s_flow;

endmodule

// ----- rtl/frustum_cull_test_top.sv -----
`timescale 1ns / 1ps
// Frustum cull test: six planes (a,b,c,d) in Q16.16 and a box / sphere
// visibility test against them.
//
// Request channel: present i_req with start high; the request is taken at
// a clock edge where start is high and busy is low. busy is high during reset
// and in the cycle after it, so one request can be taken in every cycle.
// Commands: load plane, box against all planes, box skipping near, box
// against the sides only, sphere. Unused commands and loads to a plane index
// above five change nothing and are acknowledged like a load.
//
// Result channel: o_done strobes for exactly one cycle with o_rsp. Every
// request yields one result, in request order. The receiver cannot stall.
//
// Throughput is one request per cycle whenever busy is low. An accepted
// request passes the input register, then the chain of six plane cells,
// two register stages each (multiply, then sum and sign check), and its
// result leaves the last cell on o_done. A plane load travels the
// chain and writes its cell as it passes, so tests stay in request order.
//
// Reset clears all planes to zero and empties the chain.
module frustum_cull_test_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fct_pkg::t_req i_req,
    output logic          o_done,
    output fct_pkg::t_rsp o_rsp
);
    import fct_pkg::*;

    localparam int LAT = 2 * NUM_PLANES + 1;

    logic  r_busy;
    logic  accept;
    t_flow r_in;
    t_flow chain [NUM_PLANES+1];
    t_flow last;

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // hold busy for the cycle after reset only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // register the request at the chain head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in.valid <= accept;
        end
        r_in.req <= i_req;
        r_in.vis <= 1'b1;
    end

    assign chain[0] = r_in;

    // one cell per plane; each drops the visible flag if its plane rejects
    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
        fct_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_flow (chain[g]),
            .o_flow (chain[g+1])
        );
    end

    assign last = chain[NUM_PLANES];

    assign o_done = last.valid;
    always_comb begin
        case (last.req.cmd)
            CMD_BOX_ALL, CMD_BOX_SKIP, CMD_BOX_SIDES, CMD_SPHERE: begin
                o_rsp.is_test = 1'b1;
                o_rsp.visible = last.vis;
            end
            default: begin
                o_rsp.is_test = 1'b0;
                o_rsp.visible = 1'b0;
            end
        endcase
    end

    a_done_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result strobe without a matching request");

    a_load_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(i_req.cmd == CMD_LOAD, LAT) |-> !o_rsp.is_test)
        else $error("plane load answered as a test");

    a_test_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(i_req.cmd == CMD_SPHERE, LAT) |-> o_rsp.is_test)
        else $error("sphere test lost its test flag");

    a_no_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held beyond the cycle after reset");

endmodule

// ----- bench/frustum_cull_test_top_test.sv -----
`timescale 1ns / 1ps
module frustum_cull_test_top_test;
    import fct_pkg::*;

    // Hold the last part of the stream free of idle bursts.
    localparam int CALM_TAIL    = 250;
    localparam int RANDOM_REQS  = 1925;
    // Allow a generous tail after the last result.
    localparam int DRAIN_CYCLES = 40;
    // Longest correct silence is an idle burst plus the pipeline.
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 10;

    localparam t_coord C_MAX = 32'sh7fff_ffff;
    localparam t_coord C_MIN = 32'sh8000_0000;
    localparam t_coord C_ONE = 32'sh0001_0000;
    localparam t_coord C_HALF = 32'sh0000_8000;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    logic  busy;
    t_req  i_req   = '0;
    logic  o_done;
    t_rsp  o_rsp;

    // Predictor state: a, b, c, d of each plane.
    t_coord plane_coef [NUM_PLANES][4];

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   n_total    = 0;
    int   n_taken    = 0;
    int   n_mismatch = 0;
    int   gap_left   = 0;
    int   stall_cycles = 0;
    t_rsp want;

    frustum_cull_test_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // a*x + b*y + c*z + (d << FRAC_BITS), exact, 2*FRAC_BITS fraction bits.
    function automatic logic signed [127:0] plane_distance(int p, t_coord x, t_coord y,
                                                           t_coord z);
        logic signed [127:0] acc;
        logic signed [63:0]  prod;
        acc = plane_coef[p][3];
        acc = acc <<< FRAC_BITS;
        prod = plane_coef[p][0] * x;
        acc = acc + prod;
        prod = plane_coef[p][1] * y;
        acc = acc + prod;
        prod = plane_coef[p][2] * z;
        acc = acc + prod;
        return acc;
    endfunction

    // Take the corner furthest along each plane normal; reject on a negative distance.
    function automatic logic box_passes(int first, t_req r);
        t_coord px, py, pz;
        for (int p = first; p < NUM_PLANES; p++) begin
            px = (plane_coef[p][0] < 0) ? r.val_x : r.hi_x;
            py = (plane_coef[p][1] < 0) ? r.val_y : r.hi_y;
            pz = (plane_coef[p][2] < 0) ? r.val_z : r.hi_z;
            if (plane_distance(p, px, py, pz) < 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic sphere_passes(t_req r);
        logic signed [127:0] rad;
        rad = r.val_w;
        rad = rad <<< FRAC_BITS;
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (plane_distance(p, r.val_x, r.val_y, r.val_z) + rad < 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one request to the plane copy and return the answer it earns.
    function automatic t_rsp cull_outcome(t_req r);
        t_rsp rsp;
        rsp = '0;
        case (r.cmd)
            CMD_LOAD: begin
                if (r.plane_index < NUM_PLANES) begin
                    plane_coef[r.plane_index][0] = r.val_x;
                    plane_coef[r.plane_index][1] = r.val_y;
                    plane_coef[r.plane_index][2] = r.val_z;
                    plane_coef[r.plane_index][3] = r.val_w;
                end
            end
            CMD_BOX_ALL: begin
                rsp.is_test = 1'b1;
                rsp.visible = box_passes(0, r);
            end
            CMD_BOX_SKIP: begin
                rsp.is_test = 1'b1;
                rsp.visible = box_passes(1, r);
            end
            CMD_BOX_SIDES: begin
                rsp.is_test = 1'b1;
                rsp.visible = box_passes(2, r);
            end
            CMD_SPHERE: begin
                rsp.is_test = 1'b1;
                rsp.visible = sphere_passes(r);
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_req make_req(logic [CMD_BITS-1:0] cmd, logic [IDX_BITS-1:0] idx,
                                      t_coord x, t_coord y, t_coord z, t_coord w,
                                      t_coord hx, t_coord hy, t_coord hz);
        t_req r;
        r.cmd = cmd;
        r.plane_index = idx;
        r.val_x = x;
        r.val_y = y;
        r.val_z = z;
        r.val_w = w;
        r.hi_x = hx;
        r.hi_y = hy;
        r.hi_z = hz;
        return r;
    endfunction

    // Mostly values within +-4.0, some full range, some extremes.
    function automatic t_coord pick_coord();
        logic [31:0] raw;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            raw = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        end else if (sel < 80) begin
            raw = $urandom;
        end else begin
            case ($urandom_range(0, 4))
                0: raw = 32'h8000_0000;
                1: raw = 32'h7fff_ffff;
                2: raw = 32'h0000_0000;
                3: raw = 32'hffff_ffff;
                default: raw = 32'h0000_0001;
            endcase
        end
        return raw;
    endfunction

    function automatic t_req random_req();
        t_req        r;
        int unsigned sel;
        t_coord      lo, hi;
        r = make_req(CMD_BITS'($urandom), IDX_BITS'($urandom), $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom);
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            r.cmd = CMD_LOAD;
            r.plane_index = ($urandom_range(0, 9) == 0) ? IDX_BITS'($urandom_range(6, 7))
                                                        : IDX_BITS'($urandom_range(0, 5));
            if ($urandom_range(0, 3) == 0) begin
                // null normal with d >= 0: this plane passes everything
                r.val_x = '0;
                r.val_y = '0;
                r.val_z = '0;
                r.val_w = $urandom_range(0, 32'h0004_0000);
            end else begin
                r.val_x = pick_coord();
                r.val_y = pick_coord();
                r.val_z = pick_coord();
                r.val_w = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 32'h0004_0000)
                                                      : pick_coord();
            end
        end else if (sel < 70) begin
            r.cmd = CMD_BITS'($urandom_range(CMD_BOX_ALL, CMD_BOX_SIDES));
            r.val_x = pick_coord();
            r.val_y = pick_coord();
            r.val_z = pick_coord();
            r.hi_x = pick_coord();
            r.hi_y = pick_coord();
            r.hi_z = pick_coord();
            // keep most boxes well ordered; leave the rest inverted
            if ($urandom_range(0, 4) != 0) begin
                lo = r.val_x; hi = r.hi_x;
                if (lo > hi) begin r.val_x = hi; r.hi_x = lo; end
                lo = r.val_y; hi = r.hi_y;
                if (lo > hi) begin r.val_y = hi; r.hi_y = lo; end
                lo = r.val_z; hi = r.hi_z;
                if (lo > hi) begin r.val_z = hi; r.hi_z = lo; end
            end
        end else if (sel < 95) begin
            r.cmd = CMD_SPHERE;
            r.val_x = pick_coord();
            r.val_y = pick_coord();
            r.val_z = pick_coord();
            r.val_w = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 32'h0004_0000)
                                                  : pick_coord();
        end else begin
            r.cmd = CMD_BITS'($urandom_range(5, 7));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        // Tests against the all-zero planes after reset: nothing is rejected,
        // except a sphere with a negative radius.
        pending_reqs.push_back(make_req(CMD_BOX_ALL, 0, C_MIN, C_MIN, C_MIN, 0,
                                        C_MAX, C_MAX, C_MAX));
        pending_reqs.push_back(make_req(CMD_SPHERE, 0, 0, 0, 0, -C_ONE, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_SPHERE, 7, C_MAX, C_MIN, 0, 0, 0, 0, 0));
        // Unused commands change nothing and answer like a load.
        for (int c = 5; c <= 7; c++) begin
            pending_reqs.push_back(make_req(CMD_BITS'(c), IDX_BITS'($urandom), $urandom,
                                            $urandom, $urandom, $urandom, $urandom,
                                            $urandom, $urandom));
        end
        // Loads to plane indexes past the last plane write nothing.
        pending_reqs.push_back(make_req(CMD_LOAD, 6, C_ONE, C_ONE, C_ONE, C_MIN, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_LOAD, 7, -C_ONE, 0, 0, C_MIN, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_BOX_ALL, 0, C_ONE, C_ONE, C_ONE, 0,
                                        C_ONE, C_ONE, C_ONE));
        // Near and far carry extreme coefficients; the sides bound x and y to a 2.0 wide column along z.
        pending_reqs.push_back(make_req(CMD_LOAD, 0, C_MAX, C_MIN, C_ONE, C_MIN, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_LOAD, 1, C_MIN, C_MIN, C_MIN, C_MAX, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_LOAD, 2, C_ONE, 0, 0, C_ONE, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_LOAD, 3, -C_ONE, 0, 0, C_ONE, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_LOAD, 4, 0, C_ONE, 0, C_ONE, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_LOAD, 5, 0, -C_ONE, 0, C_ONE, 0, 0, 0));
        // One small box through all three plane subsets.
        for (int c = CMD_BOX_ALL; c <= CMD_BOX_SIDES; c++) begin
            pending_reqs.push_back(make_req(CMD_BITS'(c), 0, -C_HALF, -C_HALF, -C_HALF, 0,
                                            C_HALF, C_HALF, C_HALF));
        end
        // Box fully right of the column; inverted box across the left plane.
        pending_reqs.push_back(make_req(CMD_BOX_SIDES, 0, 5 * C_ONE, 0, 0, 0,
                                        6 * C_ONE, C_HALF, C_HALF));
        pending_reqs.push_back(make_req(CMD_BOX_SIDES, 0, 2 * C_ONE, 0, 0, 0,
                                        -2 * C_ONE, 0, 0));
        // Extreme boxes, normal and inverted.
        pending_reqs.push_back(make_req(CMD_BOX_ALL, 0, C_MIN, C_MIN, C_MIN, 0,
                                        C_MAX, C_MAX, C_MAX));
        pending_reqs.push_back(make_req(CMD_BOX_SKIP, 0, C_MAX, C_MAX, C_MAX, 0,
                                        C_MIN, C_MIN, C_MIN));
        // Spheres: zero radius, just outside, huge radius, negative radius.
        pending_reqs.push_back(make_req(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_SPHERE, 0, 3 * C_ONE, 0, 0, C_ONE, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_SPHERE, 0, C_MIN, C_MAX, 0, C_MAX, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_SPHERE, 0, 0, 0, 0, C_MIN, 0, 0, 0));

        for (int n = 0; n < RANDOM_REQS; n++) pending_reqs.push_back(random_req());
        n_total = pending_reqs.size();

        // hold reset, then release it once
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_taken == n_total);
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        // any expectation still waiting is a missing result
        n_mismatch = n_mismatch + expected_rsps.size();
        if (n_mismatch == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: present the next request once the current one is taken,
    // with random idle bursts outside the calm tail.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                start <= 1'b0;
            end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                // this cycle is the first of a random idle burst
                gap_left = $urandom_range(0, 2);
                start <= 1'b0;
            end else begin
                i_req <= pending_reqs.pop_front();
                start <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict each taken request, check each strobed result
    // against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_rsps.push_back(cull_outcome(i_req));
                n_taken++;
            end
            // treat an unknown strobe as a result so it cannot slip by
            if (o_done !== 1'b0) begin
                if (expected_rsps.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("unexpected result at %0t: is_test %b visible %b",
                                 $realtime, o_rsp.is_test, o_rsp.visible);
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_rsp.is_test !== want.is_test || o_rsp.visible !== want.visible)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS)
                            $display({"result mismatch at %0t: is_test exp %b got %b, ",
                                      "visible exp %b got %b"}, $realtime,
                                     want.is_test, o_rsp.is_test,
                                     want.visible, o_rsp.visible);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
rtl/fct_pkg.sv
rtl/fct_cell.sv
rtl/frustum_cull_test_top.sv
bench/frustum_cull_test_top_test.sv
